// File: sv/xde_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xde_pkg
// types, codes and helpers shared by the x-drop ungapped extension block
// ----------------------------------------------------------------------------
package xde_pkg;

  // command codes of an input word
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_LEFT  = 2'd1;
  localparam logic [1:0] CMD_RIGHT = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_XDROP     = 2'd0;
  localparam logic [1:0] CFG_DELIMITER = 2'd1;
  localparam logic [1:0] CFG_COUNT_ID  = 2'd2;

  localparam int CFG_DATA_W = 10;

  // counter saturation value (17 bits all ones)
  localparam logic [16:0] CNT_MAX = 17'h1FFFF;
  // output score saturation value
  localparam logic [23:0] SCORE_OUT_MAX = 24'd8388607;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LEFT,
    PH_RIGHT
  } phase_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [4:0]         query_letter;
    logic [4:0]         subject_letter;
    logic signed [7:0]  table_score;
    logic signed [7:0]  bias;
    logic [15:0]        seed_query_pos;
    logic [15:0]        seed_subject_pos;
    logic               last;
  } in_word_t;

  typedef struct packed {
    logic [15:0] query_start;
    logic [15:0] subject_start;
    logic [15:0] segment_length;
    logic [22:0] segment_score;
    logic [15:0] identity_count;
  } out_word_t;

  typedef struct packed {
    logic [9:0] xdrop_limit;
    logic [4:0] delimiter_code;
    logic       ident_en;
  } cfg_t;

  // unformatted segment as captured at the end of an extension
  typedef struct packed {
    logic [15:0] seed_query_pos;
    logic [15:0] seed_subject_pos;
    logic [16:0] left_extent;
    logic [16:0] right_extent;
    logic [23:0] best_score;
    logic [16:0] identities;
  } res_raw_t;

  function automatic logic [16:0] sat_add17(input logic [16:0] a, input logic [16:0] b);
    logic [17:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[17] ? CNT_MAX : s[16:0];
  endfunction

endpackage
`default_nettype wire

// File: sv/xdrop_ungapped_extension.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xdrop_ungapped_extension
// x-drop ungapped seed extension along one diagonal with a loadable table
// ----------------------------------------------------------------------------
// The block takes one word per clock unless stalled: table loads (cmd 0),
// left pairs walking away from the seed (cmd 1) and right pairs from the
// seed on (cmd 2). Each word is registered together with its substitution
// table read, and from that pair register the score recurrence (add,
// saturate, compare with best and with the x-drop limit) updates the
// extension state; the right pair marked last loads the segment register and
// raises out_valid as it leaves the pair register. Sustained rate is one word
// per cycle while no finishing pair is held. Input stall rises only when a
// finishing pair waits behind an unread segment; all other words keep
// flowing. The table holds ALPHABET_SIZE squared entries and has no reset:
// load every entry that pairs will touch before extending. The user must
// write configuration through cfg_wr_en / cfg_index / cfg_data only while
// the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module xdrop_ungapped_extension #(
  parameter int ALPHABET_SIZE = 32,
  parameter int MAX_POSITION  = 65535
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // configuration
  input  wire logic                            cfg_wr_en,
  input  wire logic [1:0]                      cfg_index,
  input  wire logic [xde_pkg::CFG_DATA_W-1:0]  cfg_data,
  // pair / table word channel
  input  wire logic                            in_valid,
  output      logic                            in_stall,
  input  wire xde_pkg::in_word_t               in_word,
  // segment channel
  output      logic                            out_valid,
  input  wire logic                            out_stall,
  output      xde_pkg::out_word_t              out_word
);

  import xde_pkg::*;

  localparam int DEPTH  = ALPHABET_SIZE * ALPHABET_SIZE;
  localparam int ADDR_W = $clog2(DEPTH);

  cfg_t               cfg;
  logic               accept;
  logic               in_range;
  logic [ADDR_W-1:0]  tbl_addr;
  logic               tbl_wr;
  logic signed [7:0]  tbl_data;
  res_raw_t           res_raw;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.xdrop_limit    <= 10'd20;
      cfg.delimiter_code <= 5'd31;
      cfg.ident_en       <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_XDROP:     cfg.xdrop_limit    <= cfg_data[9:0];
        CFG_DELIMITER: cfg.delimiter_code <= cfg_data[4:0];
        CFG_COUNT_ID:  cfg.ident_en       <= cfg_data[0];
        default:       ;
      endcase
    end
  end

  assign accept = in_valid && !in_stall;

  // table address of the pair; letters outside the alphabet score zero
  always_comb begin
    in_range = (int'(in_word.query_letter) < ALPHABET_SIZE) &&
               (int'(in_word.subject_letter) < ALPHABET_SIZE);
    tbl_addr = ADDR_W'(int'(in_word.query_letter) * ALPHABET_SIZE +
                       int'(in_word.subject_letter));
  end

  // a table load writes at acceptance; every word reads its entry then too
  assign tbl_wr = accept && (in_word.cmd == CMD_WRITE) && in_range;

  xde_table #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr),
    .wr_addr (tbl_addr),
    .wr_data (in_word.table_score),
    .rd_en   (accept),
    .rd_addr (tbl_addr),
    .rd_data (tbl_data)
  );

  // recurrence and extension state
  xde_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_word   (in_word),
    .in_range  (in_range),
    .in_stall  (in_stall),
    .tbl_data  (tbl_data),
    .res_valid (out_valid),
    .res_raw   (res_raw),
    .res_stall (out_stall)
  );

  // output saturation and start positions from the held segment
  xde_fmt #(
    .MAX_POSITION (MAX_POSITION)
  ) u_fmt (
    .raw  (res_raw),
    .word (out_word)
  );

endmodule
`default_nettype wire

// File: sv/xde_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xde_table
// substitution score memory, one write port, one registered read port
// ----------------------------------------------------------------------------
module xde_table #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  wire logic                clk,
  input  wire logic                wr_en,
  input  wire logic [ADDR_W-1:0]   wr_addr,
  input  wire logic signed [7:0]   wr_data,
  input  wire logic                rd_en,
  input  wire logic [ADDR_W-1:0]   rd_addr,
  output      logic signed [7:0]   rd_data
);

  logic signed [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: sv/xde_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xde_core
// pair register, score recurrence and extension state, segment register
// ----------------------------------------------------------------------------
module xde_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire xde_pkg::cfg_t      cfg,
  input  wire logic               in_valid,
  input  wire xde_pkg::in_word_t  in_word,
  input  wire logic               in_range,
  output      logic               in_stall,
  input  wire logic signed [7:0]  tbl_data,
  output      logic               res_valid,
  output      xde_pkg::res_raw_t  res_raw,
  input  wire logic               res_stall
);

  import xde_pkg::*;

  // pair stage
  logic      a_valid;
  in_word_t  a_word;
  logic      a_range;

  // extension state
  phase_t             phase, phase_next;
  logic [23:0]        best, best_next;
  logic signed [24:0] run, run_next;
  logic [16:0]        step, step_next;
  logic [16:0]        left_ext, left_ext_next;
  logic [16:0]        right_ext, right_ext_next;
  logic [16:0]        comm, comm_next;
  logic [16:0]        pend, pend_next;
  logic               stopped, stopped_next;

  logic               emit, blocked, exec, accept;

  // working values
  logic               clear, enter_right, pair, stop_hit, ident;
  logic [23:0]        b_best;
  logic signed [24:0] b_run, r_sat;
  logic [16:0]        b_step, b_left, b_right, b_comm, b_pend, pend_inc;
  logic               b_stop;
  logic signed [25:0] drop, sum;
  logic signed [7:0]  ts_eff;

  assign emit     = a_valid && (a_word.cmd == CMD_RIGHT) && a_word.last;
  assign blocked  = emit && res_valid && res_stall;
  assign exec     = a_valid && !blocked;
  assign in_stall = a_valid && blocked;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (!in_stall) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_word  <= in_word;
      a_range <= in_range;
    end
  end

  always_comb begin
    clear       = ((a_word.cmd == CMD_LEFT) && (phase != PH_LEFT)) ||
                  ((a_word.cmd == CMD_RIGHT) && (phase == PH_IDLE));
    enter_right = (a_word.cmd == CMD_RIGHT) && (phase != PH_RIGHT);
    pair        = (a_word.cmd == CMD_LEFT) || (a_word.cmd == CMD_RIGHT);

    b_best  = clear ? 24'd0 : best;
    b_run   = clear ? 25'sd0 : run;
    b_step  = clear ? 17'd1 : step;
    b_left  = clear ? 17'd0 : left_ext;
    b_right = clear ? 17'd0 : right_ext;
    b_comm  = clear ? 17'd0 : comm;
    b_pend  = clear ? 17'd0 : pend;
    b_stop  = clear ? 1'b0 : stopped;
    if (enter_right) begin
      b_run  = $signed({1'b0, b_best});
      b_step = 17'd1;
      b_pend = 17'd0;
      b_stop = 1'b0;
    end

    drop     = $signed({2'b00, b_best}) - $signed({b_run[24], b_run});
    stop_hit = (drop >= $signed({16'd0, cfg.xdrop_limit})) ||
               (a_word.query_letter == cfg.delimiter_code) ||
               (a_word.subject_letter == cfg.delimiter_code);

    ts_eff = a_range ? tbl_data : 8'sd0;
    sum    = $signed({b_run[24], b_run}) + $signed({{18{ts_eff[7]}}, ts_eff}) +
             $signed({{18{a_word.bias[7]}}, a_word.bias});
    // 25-bit signed saturation
    if (sum[25] != sum[24]) begin
      r_sat = sum[25] ? {1'b1, 24'd0} : {1'b0, {24{1'b1}}};
    end else begin
      r_sat = sum[24:0];
    end

    ident    = cfg.ident_en && (a_word.query_letter == a_word.subject_letter);
    pend_inc = sat_add17(b_pend, {16'd0, ident});

    best_next      = best;
    run_next       = run;
    step_next      = step;
    left_ext_next  = left_ext;
    right_ext_next = right_ext;
    comm_next      = comm;
    pend_next      = pend;
    stopped_next   = stopped;
    phase_next     = phase;

    if (pair) begin
      best_next      = b_best;
      run_next       = b_run;
      step_next      = b_step;
      left_ext_next  = b_left;
      right_ext_next = b_right;
      comm_next      = b_comm;
      pend_next      = b_pend;
      stopped_next   = b_stop;
      if (!b_stop) begin
        if (stop_hit) begin
          stopped_next = 1'b1;
        end else begin
          run_next  = r_sat;
          pend_next = pend_inc;
          if (r_sat > $signed({1'b0, b_best})) begin
            best_next = r_sat[23:0];
            if (a_word.cmd == CMD_LEFT) begin
              left_ext_next = b_step;
            end else begin
              right_ext_next = b_step;
            end
            comm_next = sat_add17(b_comm, pend_inc);
            pend_next = 17'd0;
          end
          step_next = sat_add17(b_step, 17'd1);
        end
      end
    end

    case (a_word.cmd)
      CMD_LEFT:  phase_next = PH_LEFT;
      CMD_RIGHT: phase_next = a_word.last ? PH_IDLE : PH_RIGHT;
      default:   phase_next = phase;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      best      <= 24'd0;
      run       <= 25'sd0;
      step      <= 17'd1;
      left_ext  <= 17'd0;
      right_ext <= 17'd0;
      comm      <= 17'd0;
      pend      <= 17'd0;
      stopped   <= 1'b0;
    end else if (exec) begin
      phase     <= phase_next;
      best      <= best_next;
      run       <= run_next;
      step      <= step_next;
      left_ext  <= left_ext_next;
      right_ext <= right_ext_next;
      comm      <= comm_next;
      pend      <= pend_next;
      stopped   <= stopped_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (exec && emit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec && emit) begin
      res_raw.seed_query_pos   <= a_word.seed_query_pos;
      res_raw.seed_subject_pos <= a_word.seed_subject_pos;
      res_raw.left_extent      <= left_ext_next;
      res_raw.right_extent     <= right_ext_next;
      res_raw.best_score       <= best_next;
      res_raw.identities       <= cfg.ident_en ? comm_next : 17'd0;
    end
  end

endmodule
`default_nettype wire

// File: sv/xde_fmt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xde_fmt
// turns the captured segment into start positions, length, score and count
// ----------------------------------------------------------------------------
module xde_fmt #(
  parameter int MAX_POSITION = 65535
) (
  input  wire xde_pkg::res_raw_t   raw,
  output      xde_pkg::out_word_t  word
);

  import xde_pkg::*;

  localparam int LIM = (MAX_POSITION < 65535) ? MAX_POSITION : 65535;
  localparam logic [17:0] LIM18 = 18'(LIM);

  logic [17:0] len;

  always_comb begin
    len = {1'b0, raw.left_extent} + {1'b0, raw.right_extent};

    word.query_start   = ({1'b0, raw.seed_query_pos} >= raw.left_extent) ?
                         16'({1'b0, raw.seed_query_pos} - raw.left_extent) : 16'd0;
    word.subject_start = ({1'b0, raw.seed_subject_pos} >= raw.left_extent) ?
                         16'({1'b0, raw.seed_subject_pos} - raw.left_extent) : 16'd0;
    word.segment_length = (len > LIM18) ? LIM18[15:0] : len[15:0];
    word.identity_count = ({1'b0, raw.identities} > LIM18) ? LIM18[15:0]
                                                            : raw.identities[15:0];
    word.segment_score  = (raw.best_score > SCORE_OUT_MAX) ? SCORE_OUT_MAX[22:0]
                                                           : raw.best_score[22:0];
  end

endmodule
`default_nettype wire
